[src/ims_pkg.sv]
package ims_pkg;

  localparam int STACK_COUNT = 3;
  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;

  localparam int VAL_W      = 32;
  localparam int SID_W      = 4;
  localparam int SLOT_COUNT = STACK_COUNT * STACK_DEPTH;
  localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SIDX_W     = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam int LVL_W      = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_BAD_ID = 2'd3;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [SID_W-1:0] stack_id;
    logic [VAL_W-1:0] push_value;
  } ims_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] pop_value;
    logic [1:0]       status;
    logic             now_empty;
  } ims_out_t;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } ims_state_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } ims_cmd_t;

endpackage

[src/ims_ram.sv]
module ims_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ims_ctrl.sv]
module ims_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ims_pkg::ims_cmd_t cmd
);
  import ims_pkg::*;

  ims_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_BUSY;
        end
      end
      S_BUSY: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[src/ims_dp.sv]
module ims_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ims_pkg::ims_cmd_t cmd,
  input  ims_pkg::ims_in_t  in_data,
  output ims_pkg::ims_out_t out_data
);
  import ims_pkg::*;

  logic [LVL_W-1:0]      lvl_r [STACK_COUNT];
  logic [LVL_W-1:0]      lvl_cur, lvl_new, lvl_slot;
  logic [SIDX_W-1:0]     idx;
  logic                  id_ok;
  logic [1:0]            status_nxt, status_r;
  logic                  empty_nxt, empty_r;
  logic                  pop_ok_nxt, pop_ok_r;
  logic                  wr_en;
  logic [ADDR_W-1:0]     addr;
  logic [DATA_WIDTH-1:0] rd_data;
  ims_out_t              out_r;

  assign idx   = in_data.stack_id[SIDX_W-1:0];
  assign id_ok = {1'b0, in_data.stack_id} < (SID_W + 1)'(STACK_COUNT);

  always_comb begin
    lvl_cur    = '0;
    lvl_new    = '0;
    lvl_slot   = '0;
    status_nxt = STAT_BAD_ID;
    pop_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    if (id_ok) begin
      lvl_cur    = lvl_r[idx];
      lvl_new    = lvl_cur;
      status_nxt = STAT_OK;
      if (in_data.cmd == CMD_PUSH) begin
        lvl_slot = lvl_cur;
        if (lvl_cur >= LVL_W'(STACK_DEPTH)) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en   = cmd.accept;
          lvl_new = lvl_cur + 1'b1;
        end
      end else begin
        lvl_slot = lvl_cur - 1'b1;
        if (lvl_cur == '0) begin
          status_nxt = STAT_EMPTY;
        end else begin
          pop_ok_nxt = 1'b1;
          lvl_new    = lvl_cur - 1'b1;
        end
      end
    end
    empty_nxt = !id_ok || (lvl_new == '0);
    addr      = ADDR_W'(ADDR_W'(lvl_slot) * ADDR_W'(STACK_COUNT) + ADDR_W'(idx));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STACK_COUNT; i++) begin
        lvl_r[i] <= '0;
      end
    end else if (cmd.accept && id_ok) begin
      lvl_r[idx] <= lvl_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r <= status_nxt;
      empty_r  <= empty_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
    if (cmd.load_out) begin
      out_r.pop_value <= pop_ok_r ? VAL_W'(rd_data) : '0;
      out_r.status    <= status_r;
      out_r.now_empty <= empty_r;
    end
  end

  ims_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata (in_data.push_value[DATA_WIDTH-1:0]),
    .re    (cmd.accept && pop_ok_nxt),
    .raddr (addr),
    .rdata (rd_data)
  );

  assign out_data = out_r;

endmodule

[src/interleaved_multi_stack_core.sv]
// Requests are taken only in S_IDLE; one moves the controller to S_BUSY, which waits for a free
// output register, loads the result from the store's registered read and raises out_valid.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous): every stack empty, no result pending.
// Store contents are not cleared; a slot is read only after a push has written it.
module interleaved_multi_stack_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ims_pkg::ims_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ims_pkg::ims_out_t out_data
);
  import ims_pkg::*;

  ims_cmd_t cmd;

  ims_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ims_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still in flight");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

  a_bad_id_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STAT_BAD_ID || out_data.status == STAT_EMPTY))
      |-> out_data.now_empty)
    else $error("bad id or empty pop must report empty");

  a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STAT_OK) |-> (out_data.pop_value == '0))
    else $error("failed request returned nonzero value");

endmodule
